// File: hw/rtl/hha_dpe_pkg.sv
// Shared constants, stage record types and the half-degree cosine table for the
// HHA depth pixel encoder. No dependencies; imported by hha_depth_pixel_encoder.
package hha_dpe_pkg;

    localparam int ACOS_TABLE_BITS_DEF = 10;

    // Codes of the configuration register index.
    localparam logic [1:0] REG_ROT_ZX = 2'd0;
    localparam logic [1:0] REG_ROT_ZY = 2'd1;
    localparam logic [1:0] REG_ROT_ZZ = 2'd2;

    localparam logic signed [15:0] ROT_ZZ_RESET  = 16'sd16384;
    localparam logic signed [15:0] MIN_DEPTH_Q12 = 16'sd819;
    localparam logic [18:0]        DISP_NUM2     = 19'd417792;
    localparam logic [10:0]        HEIGHT_MUL    = 11'd1275;
    localparam logic [26:0]        HEIGHT_RND    = 27'd4096;
    localparam logic [7:0]         ANGLE_BASE    = 8'd38;
    localparam logic [7:0]         ANGLE_SPAN    = 8'd180;

    // Eight binary search steps cover the 180 half-degree thresholds, and eight
    // restoring steps give the 8-bit disparity quotient.
    localparam int SEARCH_STEPS = 8;
    localparam int TAB_DEPTH    = 256;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    typedef logic [TAB_DEPTH-1:0][31:0] cos_tab_t;

    // Unsigned 64-bit quotient by shift and subtract, used only while the
    // cosine table is built at elaboration.
    function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            quo = {quo[62:0], 1'b0};
            if (rem >= den) begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // cos((2n+1)/2 degrees) in Q30 for n = 0..179, from a 12-term Taylor series.
    // Entries past 179 hold the most negative word so a search never stops there.
    function automatic cos_tab_t build_cos_tab();
        cos_tab_t        tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            tab[i] = 32'h8000_0000;
        end
        for (int n = 0; n < 90; n++) begin
            x    = div_u64(longint'(2 * n + 1) * PI_Q30, 64'd360);
            x2   = (x * x) >> 30;
            term = ONE_Q30;
            sum  = longint'(ONE_Q30);
            for (int k = 1; k <= 12; k++) begin
                term = div_u64((term * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
                if (k[0]) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            tab[n]       = sum[31:0];
            tab[179 - n] = 32'(-sum);
        end
        return tab;
    endfunction

    localparam cos_tab_t COS_TAB = build_cos_tab();

    // Record after the multiplier stage.
    typedef struct packed {
        logic               pv;
        logic               hpos;
        logic [25:0]        hprod;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [18:0]        rem;
        logic [15:0]        dv;
    } front0_t;

    // Record after the dot product sum.
    typedef struct packed {
        logic               pv;
        logic [7:0]         hb;
        logic signed [33:0] dot;
        logic [18:0]        rem;
        logic [15:0]        dv;
    } front1_t;

    // Record carried through the search and divider steps.
    typedef struct packed {
        logic               pv;
        logic [7:0]         hb;
        logic signed [32:0] c;
        logic [7:0]         pos;
        logic [18:0]        rem;
        logic [15:0]        dv;
        logic [7:0]         q;
    } step_t;

endpackage

// File: hw/rtl/hha_depth_pixel_encoder.sv
// HHA depth pixel encoder: one depth pixel in, angle, height and disparity bytes out.
// An input transfer reaches m_tdata through 12 register stages; throughput is one pixel per
// cycle unless m_tready stalls the output, with 8 search and divider steps in the pipeline.
// aresetn is synchronous and active low; it empties the pipeline and loads the rotation
// row with (0, 0, 1.0). Depends on hha_dpe_pkg.
module hha_depth_pixel_encoder
    import hha_dpe_pkg::*;
#(
    parameter int ACOS_TABLE_BITS = ACOS_TABLE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input pixel channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // height_z, raw_depth, normal_x, normal_y, normal_z
    input  logic [0:0]  s_tuser,   // pixel_valid
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // angle_byte, height_byte, disparity_byte
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    // Rounding offset and scale of the dot product grid.
    localparam logic [29:0]        IDX_RND = 30'(1) << (28 - ACOS_TABLE_BITS);
    localparam logic signed [33:0] DOT_MAX = 34'sd268435456;
    localparam logic signed [33:0] DOT_MIN = -34'sd268435456;
    localparam logic signed [32:0] C_OFS   = 33'sd1073741824;

    // ------------------------------------------------------------------
    // Configuration: row z of the camera-to-world rotation. Writes must
    // only happen while the pipeline is empty; the block itself does not
    // enforce it, and the multipliers read these registers directly.
    // ------------------------------------------------------------------
    logic signed [15:0] rot_zx_reg;
    logic signed [15:0] rot_zy_reg;
    logic signed [15:0] rot_zz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_zx_reg <= '0;
            rot_zy_reg <= '0;
            rot_zz_reg <= ROT_ZZ_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROT_ZX: rot_zx_reg <= cfg_wdata;
                REG_ROT_ZY: rot_zy_reg <= cfg_wdata;
                REG_ROT_ZZ: rot_zz_reg <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Each stage moves when it is empty or when the stage
    // after it moves, so bubbles are squeezed out and a new transfer is
    // taken while a finished result still waits in the output register.
    // ------------------------------------------------------------------
    logic    f0_v_reg;
    logic    f1_v_reg;
    logic    st_v_reg [0:SEARCH_STEPS];
    logic    m_tvalid_reg;
    logic    adv_out;
    logic    adv_st [0:SEARCH_STEPS];
    logic    adv_f1;
    logic    adv_f0;

    always_comb begin
        adv_out = !m_tvalid_reg || m_tready;
        adv_st[SEARCH_STEPS] = !st_v_reg[SEARCH_STEPS] || adv_out;
        for (int i = SEARCH_STEPS - 1; i >= 0; i--) begin
            adv_st[i] = !st_v_reg[i] || adv_st[i + 1];
        end
        adv_f1 = !f1_v_reg || adv_st[0];
        adv_f0 = !f0_v_reg || adv_f1;
    end

    assign s_tready = adv_f0;

    // ------------------------------------------------------------------
    // Stage 0: the three rotation products, the height product and the
    // clamped depth that seeds the divider.
    // ------------------------------------------------------------------
    front0_t     f0_reg;
    front0_t     f0_next;
    logic [15:0] h_in;
    logic [15:0] d_in;
    logic [15:0] d_cl;

    always_comb begin
        h_in = s_tdata[15:0];
        d_in = s_tdata[31:16];
        d_cl = ($signed(d_in) < MIN_DEPTH_Q12) ? 16'(MIN_DEPTH_Q12) : d_in;

        f0_next.pv    = s_tuser[0];
        f0_next.hpos  = !h_in[15] && (h_in != 16'd0);
        f0_next.hprod = h_in[14:0] * HEIGHT_MUL;
        f0_next.px    = rot_zx_reg * $signed(s_tdata[47:32]);
        f0_next.py    = rot_zy_reg * $signed(s_tdata[63:48]);
        f0_next.pz    = rot_zz_reg * $signed(s_tdata[79:64]);
        // Disparity is round(208896 / d) = floor((417792 + d) / (2 d)).
        f0_next.rem   = DISP_NUM2 + 19'(d_cl);
        f0_next.dv    = {d_cl[14:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f0_v_reg <= 1'b0;
        end else if (adv_f0) begin
            f0_v_reg <= s_tvalid;
        end
        if (adv_f0) begin
            f0_reg <= f0_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: sum of the products and the finished height byte.
    // ------------------------------------------------------------------
    front1_t     f1_reg;
    front1_t     f1_next;
    logic [26:0] h_sum;
    logic [13:0] h_q;

    always_comb begin
        h_sum = {1'b0, f0_reg.hprod} + HEIGHT_RND;
        h_q   = h_sum[26:13];

        f1_next.pv  = f0_reg.pv;
        if (!f0_reg.hpos) begin
            f1_next.hb = 8'd0;
        end else if (h_q > 14'd255) begin
            f1_next.hb = 8'd255;
        end else begin
            f1_next.hb = h_q[7:0];
        end
        f1_next.dot = {{2{f0_reg.px[31]}}, f0_reg.px}
                    + {{2{f0_reg.py[31]}}, f0_reg.py}
                    + {{2{f0_reg.pz[31]}}, f0_reg.pz};
        f1_next.rem = f0_reg.rem;
        f1_next.dv  = f0_reg.dv;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_v_reg <= 1'b0;
        end else if (adv_f1) begin
            f1_v_reg <= f0_v_reg;
        end
        if (adv_f1) begin
            f1_reg <= f1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: clamp the dot product to +-1, round it to the grid of
    // 2^ACOS_TABLE_BITS steps and turn the grid point back into a Q30
    // cosine for the threshold search.
    // ------------------------------------------------------------------
    step_t                       st_reg [0:SEARCH_STEPS];
    step_t                       st0_next;
    logic signed [33:0]          dot_cl;
    logic [33:0]                 dot_sh;
    logic [29:0]                 grid_r;
    logic [ACOS_TABLE_BITS:0]    grid_idx;
    logic [31:0]                 grid_c;

    always_comb begin
        if (f1_reg.dot > DOT_MAX) begin
            dot_cl = DOT_MAX;
        end else if (f1_reg.dot < DOT_MIN) begin
            dot_cl = DOT_MIN;
        end else begin
            dot_cl = f1_reg.dot;
        end
        dot_sh   = 34'(dot_cl - DOT_MIN);
        grid_r   = dot_sh[29:0] + IDX_RND;
        grid_idx = grid_r[29:29-ACOS_TABLE_BITS];
        grid_c   = {grid_idx, {(31 - ACOS_TABLE_BITS){1'b0}}};

        st0_next.pv  = f1_reg.pv;
        st0_next.hb  = f1_reg.hb;
        st0_next.c   = $signed({1'b0, grid_c}) - C_OFS;
        st0_next.pos = 8'd0;
        st0_next.rem = f1_reg.rem;
        st0_next.dv  = f1_reg.dv;
        st0_next.q   = 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_v_reg[0] <= 1'b0;
        end else if (adv_st[0]) begin
            st_v_reg[0] <= f1_v_reg;
        end
        if (adv_st[0]) begin
            st_reg[0] <= st0_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages 3 to 10: one step of each of two searches per stage.
    // The angle is the count of half-degree cosines at or above the grid
    // cosine; since the table falls monotonically that count is found by
    // a binary search, one bit per stage. Alongside, a restoring divider
    // settles one quotient bit of the disparity per stage.
    // ------------------------------------------------------------------
    for (genvar i = 1; i <= SEARCH_STEPS; i++) begin : g_step
        localparam int BIT = SEARCH_STEPS - i;

        step_t              st_next;
        logic [7:0]         cand;
        logic signed [31:0] thr;
        logic [23:0]        rem_w;
        logic [23:0]        dsh;

        always_comb begin
            cand  = st_reg[i-1].pos | (8'd1 << BIT);
            thr   = $signed(COS_TAB[cand - 8'd1]);
            rem_w = {5'd0, st_reg[i-1].rem};
            dsh   = {8'd0, st_reg[i-1].dv} << BIT;

            st_next = st_reg[i-1];
            if ($signed({thr[31], thr}) >= st_reg[i-1].c) begin
                st_next.pos = cand;
            end
            if (rem_w >= dsh) begin
                st_next.rem = 19'(rem_w - dsh);
                st_next.q   = st_reg[i-1].q | (8'd1 << BIT);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_v_reg[i] <= 1'b0;
            end else if (adv_st[i]) begin
                st_v_reg[i] <= st_v_reg[i-1];
            end
            if (adv_st[i]) begin
                st_reg[i] <= st_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: output register. An invalid pixel gives three zero bytes.
    // ------------------------------------------------------------------
    logic [23:0] out_reg;
    logic [23:0] out_next;

    always_comb begin
        if (st_reg[SEARCH_STEPS].pv) begin
            out_next = {st_reg[SEARCH_STEPS].q,
                        st_reg[SEARCH_STEPS].hb,
                        ANGLE_BASE + st_reg[SEARCH_STEPS].pos};
        end else begin
            out_next = 24'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv_out) begin
            m_tvalid_reg <= st_v_reg[SEARCH_STEPS];
        end
        if (adv_out) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_accept_fills_stage0: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> f0_v_reg)
        else $error("accepted pixel did not enter stage 0");

    a_div_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        st_v_reg[SEARCH_STEPS] |->
            (st_reg[SEARCH_STEPS].rem < {3'd0, st_reg[SEARCH_STEPS].dv}))
        else $error("disparity divider left a remainder not below the divisor");

    a_search_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st_v_reg[SEARCH_STEPS] |-> (st_reg[SEARCH_STEPS].pos <= ANGLE_SPAN))
        else $error("angle search ran past the last half-degree threshold");

    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[7:0] == 8'd0) ||
                      ((m_tdata[7:0] >= ANGLE_BASE) &&
                       (m_tdata[7:0] <= ANGLE_BASE + ANGLE_SPAN))))
        else $error("angle byte out of range");

    a_invalid_all_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[7:0] == 8'd0)) |-> (m_tdata[23:8] == 16'd0))
        else $error("zero angle byte with nonzero height or disparity");

endmodule

// File: dv/hha_depth_pixel_encoder_test.sv
// Self-checking testbench for hha_depth_pixel_encoder: pixel stream in, HHA bytes out.
// A behavioral model predicts every result; depends on hha_dpe_pkg and the encoder RTL.
`timescale 1ns / 100ps

module hha_depth_pixel_encoder_test;
    import hha_dpe_pkg::*;

    typedef longint unsigned u64_t;

    // The instance uses the default arc cosine grid; the model builds the same grid.
    localparam int GRID_BITS      = 10;
    localparam int GRID_POINTS    = (1 << GRID_BITS) + 1;
    localparam int PIPE_LATENCY   = 11;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_REPORTS    = 10;

    // Fixed-point constants of the encoding.
    localparam u64_t    PI_Q30       = 64'd3373259426;
    localparam longint  ONE_Q30      = 64'sd1073741824;
    localparam longint  DEPTH_FLOOR  = 819;      // 0.2 m in Q.12
    localparam longint  DISP_NUM_X2  = 417792;   // 2 * 51 * 4096
    localparam longint  HEIGHT_GAIN  = 1275;     // 637.5 per metre, over 2^13 with Q.12
    localparam longint  ANGLE_OFFSET = 38;

    // One pixel as it travels on the input channel.
    typedef struct packed {
        logic               valid;
        logic signed [15:0] height;
        logic signed [15:0] depth;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } pixel_t;

    // The three bytes of an HHA code.
    typedef struct packed {
        logic [7:0] disparity;
        logic [7:0] height;
        logic [7:0] angle;
    } hha_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata   = '0;   // height_z, raw_depth, normal_x, normal_y, normal_z
    logic [0:0]  s_tuser   = '0;   // pixel_valid
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // angle_byte, height_byte, disparity_byte
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = REG_ROT_ZX;
    logic [15:0] cfg_wdata = '0;

    // Model state: the arc cosine grid and the shadow of the rotation row.
    longint      half_deg_cos_q30 [0:179];
    logic [7:0]  acos_lut [0:GRID_POINTS-1];
    longint      rot_zx_q14 = 0;
    longint      rot_zy_q14 = 0;
    longint      rot_zz_q14 = 16384;

    pixel_t      pixels_to_send [$];
    hha_t        pending_codes [$];
    pixel_t      next_px;

    // Flow control knobs, changed by the stimulus process between phases.
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_requests  = 0;
    int          holds_taken    = 0;
    int          hold_left      = 0;

    int          fault_count    = 0;
    int          quiet_cycles   = 0;

    hha_depth_pixel_encoder #(
        .ACOS_TABLE_BITS(GRID_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Works out the HHA code of one pixel under the current rotation row.
    function automatic hha_t encode_pixel(pixel_t px);
        hha_t   code;
        longint hgt;
        longint dep;
        longint dot;
        longint quot;
        longint grid;
        code = '0;
        if (px.valid) begin
            // Height code: only heights above the floor count, rounded half up.
            hgt = longint'($signed(px.height));
            if (hgt > 0) begin
                quot = (hgt * HEIGHT_GAIN + 4096) >>> 13;
                code.height = (quot > 255) ? 8'd255 : quot[7:0];
            end

            // Disparity code: the depth is held at 0.2 m or more before the divide.
            dep = longint'($signed(px.depth));
            if (dep < DEPTH_FLOOR) begin
                dep = DEPTH_FLOOR;
            end
            quot = (DISP_NUM_X2 + dep) / (2 * dep);
            code.disparity = (quot > 255) ? 8'd255 : quot[7:0];

            // Angle code: world z of the normal, clamped to +-1, snapped to the grid.
            dot = rot_zx_q14 * longint'($signed(px.nx))
                + rot_zy_q14 * longint'($signed(px.ny))
                + rot_zz_q14 * longint'($signed(px.nz));
            if (dot > (longint'(1) << 28)) begin
                dot = longint'(1) << 28;
            end
            if (dot < -(longint'(1) << 28)) begin
                dot = -(longint'(1) << 28);
            end
            grid = (dot + (longint'(1) << 28) + (longint'(1) << (28 - GRID_BITS)))
                   >>> (29 - GRID_BITS);
            if (grid > GRID_POINTS - 1) begin
                grid = GRID_POINTS - 1;
            end
            code.angle = 8'(ANGLE_OFFSET + longint'(acos_lut[grid]));
        end
        return code;
    endfunction

    function automatic logic signed [15:0] rand_q14();
        return 16'(int'($urandom_range(32768)) - 16384);
    endfunction

    function automatic void push_pixel(logic valid, int height, int depth,
                                       int nx, int ny, int nz);
        pixel_t px;
        px.valid  = valid;
        px.height = 16'(height);
        px.depth  = 16'(depth);
        px.nx     = 16'(nx);
        px.ny     = 16'(ny);
        px.nz     = 16'(nz);
        pixels_to_send.insert(pixels_to_send.size(), px);
    endfunction

    // Random pixels, weighted toward the interesting ranges: heights near the
    // saturation point, depths near the 0.2 m floor, and normals along a single
    // axis so that the dot product sweeps the grid without hitting the clamp.
    task automatic push_random_pixels(int count);
        pixel_t px;
        int     shape;
        for (int n = 0; n < count; n++) begin
            px.valid  = ($urandom_range(99) < 88);
            px.height = ($urandom_range(2) == 0) ? 16'($urandom)
                                                 : 16'(int'($urandom_range(1720)) - 20);
            px.depth  = ($urandom_range(2) == 0) ? 16'($urandom)
                                                 : 16'(int'($urandom_range(3000)) - 50);
            px.nx     = rand_q14();
            px.ny     = rand_q14();
            px.nz     = rand_q14();
            shape     = $urandom_range(3);
            if (shape == 1) begin
                px.ny = '0;
                px.nz = '0;
            end else if (shape == 2) begin
                px.nx = '0;
                px.nz = '0;
            end else if (shape == 3) begin
                px.nx = '0;
                px.ny = '0;
            end
            pixels_to_send.insert(pixels_to_send.size(), px);
        end
    endtask

    // Blocks until every queued pixel went in and every result came out, then
    // waits on for the pipeline to settle.
    task automatic wait_pipeline_empty();
        do begin
            @(posedge aclk);
        end while (pixels_to_send.size() != 0 || s_tvalid || pending_codes.size() != 0);
        repeat (PIPE_LATENCY + 8) @(posedge aclk);
    endtask

    // Writes the whole rotation row, one register per cycle, and mirrors it in
    // the model. Only called while the pipeline is empty.
    task automatic set_rotation(int zx, int zy, int zz);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_ROT_ZX;
        cfg_wdata <= 16'(zx);
        @(posedge aclk);
        cfg_index <= REG_ROT_ZY;
        cfg_wdata <= 16'(zy);
        @(posedge aclk);
        cfg_index <= REG_ROT_ZZ;
        cfg_wdata <= 16'(zz);
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        rot_zx_q14 = longint'($signed(16'(zx)));
        rot_zy_q14 = longint'($signed(16'(zy)));
        rot_zz_q14 = longint'($signed(16'(zz)));
    endtask

    // Sender. A new pixel is offered only when the previous one was taken or
    // none was on the bus, so tvalid stays up across back-to-back transfers.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_px  = pixels_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {next_px.nz, next_px.ny, next_px.nx, next_px.depth, next_px.height};
                s_tuser  <= next_px.valid;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver. A hold request from the stimulus process starts a long stretch
    // with tready low, counted here; otherwise tready follows the stall rate.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holds_taken != hold_requests) begin
            holds_taken = hold_requests;
            hold_left   = HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor. The result side is checked before the input side adds its
    // prediction, so a transfer in this cycle never meets its own expectation.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_codes.size() == 0) begin
                    fault_count = fault_count + 1;
                    if (fault_count <= MAX_REPORTS) begin
                        $display("%0t: result transfer %h with no pixel outstanding",
                                 $realtime, m_tdata);
                    end
                end else begin
                    automatic hha_t want = pending_codes.pop_front();
                    automatic hha_t got  = m_tdata;
                    if (got.angle !== want.angle || got.height !== want.height
                            || got.disparity !== want.disparity) begin
                        fault_count = fault_count + 1;
                        if (fault_count <= MAX_REPORTS) begin
                            $display({"%0t: code mismatch: expected angle %0d height %0d ",
                                      "disparity %0d, got angle %0d height %0d disparity %0d"},
                                     $realtime, want.angle, want.height, want.disparity,
                                     got.angle, got.height, got.disparity);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pending_codes.insert(pending_codes.size(),
                                     encode_pixel({s_tuser[0], s_tdata[15:0],
                                                   s_tdata[31:16], s_tdata[47:32],
                                                   s_tdata[63:48], s_tdata[79:64]}));
            end
        end
    end

    // Watchdog: a long run of cycles without any transfer means a hang.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        u64_t   x;
        u64_t   x2;
        u64_t   term;
        longint sum;
        longint thresh;
        int     k;

        // Cosines of the half degrees in Q30 by a twelve-term Taylor series,
        // mirrored for the upper half of the circle.
        for (int n = 0; n < 90; n++) begin
            x    = (u64_t'(2 * n + 1) * PI_Q30) / 64'd360;
            x2   = (x * x) >> 30;
            term = u64_t'(ONE_Q30);
            sum  = ONE_Q30;
            for (int j = 1; j <= 12; j++) begin
                term = ((term * x2) >> 30) / u64_t'((2 * j - 1) * (2 * j));
                if (j % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            half_deg_cos_q30[n]       = sum;
            half_deg_cos_q30[179 - n] = -sum;
        end
        // Each grid point gets the count of half-degree cosines at or above it,
        // which is the angle rounded to whole degrees.
        k = 180;
        for (int i = 0; i < GRID_POINTS; i++) begin
            thresh = -ONE_Q30 + longint'(i) * (longint'(1) << (31 - GRID_BITS));
            while (k > 0 && half_deg_cos_q30[k - 1] < thresh) begin
                k = k - 1;
            end
            acos_lut[i] = 8'(k);
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(posedge aclk);

        // Phase 1: rotation from reset, straight up. Directed corners, no idling.
        push_pixel(1'b0, 1000, 2000, 100, 200, 16384);      // invalid pixel, busy fields
        push_pixel(1'b0, -1, -1, -16384, -16384, -16384);   // invalid pixel, all bits set in height and depth
        push_pixel(1'b1, 0, 819, 0, 0, 16384);              // zero height, depth at floor
        push_pixel(1'b1, -32768, -32768, 0, 0, -16384);     // most negative height and depth
        push_pixel(1'b1, 32767, 32767, 16384, 16384, 0);    // largest height and depth
        push_pixel(1'b1, 1, 0, 0, 0, 0);                    // zero depth, zero normal
        push_pixel(1'b1, 1635, 818, 0, 0, 8192);            // just under height saturation
        push_pixel(1'b1, 1636, 820, 0, 0, -8192);           // just at height saturation
        push_pixel(1'b1, 3, 1638, 0, 0, 11585);             // height rounds down to zero
        push_pixel(1'b1, 4, 1639, 0, 0, -11585);            // height rounds up to one
        push_pixel(1'b1, 800, 1, 0, 0, 1);                  // tiny positive depth
        push_pixel(1'b1, 2000, 4096, 0, 0, -1);             // one metre of depth
        push_pixel(1'b1, 1234, 16384, -16384, 16384, 16383);
        push_random_pixels(150);
        wait_pipeline_empty();

        // Phase 2: all-ones rotation row, so the dot product overshoots both
        // ways and the clamp applies. Sender mostly idle.
        set_rotation(16384, 16384, 16384);
        send_idle_pct  = 82;
        recv_stall_pct = 0;
        push_pixel(1'b1, 500, 1000, 16384, 16384, 16384);
        push_pixel(1'b1, 500, 1000, -16384, -16384, -16384);
        push_pixel(1'b1, 500, 1000, 16384, -16384, 8192);
        push_pixel(1'b1, 500, 1000, 16384, 16384, -16384);
        push_random_pixels(200);
        wait_pipeline_empty();

        // Phase 3: minus one in every register, receiver stalling.
        set_rotation(-16384, -16384, -16384);
        send_idle_pct  = 0;
        recv_stall_pct = 82;
        push_random_pixels(200);
        wait_pipeline_empty();

        // Phase 4: a random rotation row, light idling on both sides.
        set_rotation(rand_q14(), rand_q14(), rand_q14());
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        push_random_pixels(200);
        wait_pipeline_empty();

        // Phase 5: a tilted unit row. The receiver holds off for a long stretch
        // while pixels keep coming, so the pipeline fills and backs up its input.
        set_rotation(11585, 0, -11585);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_random_pixels(250);
        hold_requests = hold_requests + 1;
        wait_pipeline_empty();

        if (fault_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
